/* design/rc_link_frame_decoder_failsafe_defines.svh */
// ---------------------------------------------------------------------------
// rc_link_frame_decoder_failsafe_defines.svh
// Assertion macros shared by the frame decoder RTL.
// ---------------------------------------------------------------------------
`ifndef RC_LINK_FRAME_DECODER_FAILSAFE_DEFINES_SVH
`define RC_LINK_FRAME_DECODER_FAILSAFE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define RCLFD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define RCLFD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/rclfd_pkg.sv */
// ---------------------------------------------------------------------------
// rclfd_pkg
// Types and constants of the radio link frame decoder.
// ---------------------------------------------------------------------------
package rclfd_pkg;

	localparam int unsigned LOSS_W = 16;
	localparam int unsigned HOLD_W = 8;
	localparam int unsigned BYTE_W = 8;
	localparam int unsigned SEQ_W  = 3;
	localparam int unsigned ADDR_W = 5;
	localparam int unsigned DATA_W = 32;

	localparam logic [LOSS_W-1:0] LOSS_MAX = {LOSS_W{1'b1}};
	localparam logic [BYTE_W-1:0] ALT_LOST = 8'h9C;  // -100

	// status byte layout
	localparam int unsigned FLY_BIT     = 7;
	localparam int unsigned ENGINE_BIT  = 6;
	localparam int unsigned RIGHT_BIT   = 5;
	localparam int unsigned LEFT_BIT    = 4;
	localparam int unsigned SPECIAL_BIT = 3;

	// register reset values
	localparam logic [LOSS_W-1:0] RST_SIGNAL_RESET = 16'd10;
	localparam logic [LOSS_W-1:0] RST_DISARM       = 16'd15;
	localparam logic [LOSS_W-1:0] RST_FAULT        = 16'd6000;
	localparam logic [HOLD_W-1:0] RST_BUTTON_HOLD  = 8'd50;
	localparam logic [HOLD_W-1:0] RST_OPTION_HOLD  = 8'd10;

	typedef enum logic [2:0] {
		REG_SIGNAL_RESET = 3'd0,
		REG_DISARM       = 3'd1,
		REG_FAULT        = 3'd2,
		REG_BUTTON_HOLD  = 3'd3,
		REG_OPTION_HOLD  = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic [LOSS_W-1:0] signal_reset;
		logic [LOSS_W-1:0] disarm;
		logic [LOSS_W-1:0] fault;
		logic [HOLD_W-1:0] button_hold;
		logic [HOLD_W-1:0] option_hold;
	} cfg_t;

	typedef struct packed {
		logic              link_ok;
		logic [BYTE_W-1:0] status;
		logic [BYTE_W-1:0] roll;
		logic [BYTE_W-1:0] pitch;
		logic [BYTE_W-1:0] yaw;
		logic [BYTE_W-1:0] alt;
		logic [BYTE_W-1:0] opt_num;
		logic [BYTE_W-1:0] opt_val;
	} item_t;

	typedef struct packed {
		logic [SEQ_W-1:0]  seq;
		logic [LOSS_W-1:0] loss;
		logic              engine;
		logic              fly;
		logic [HOLD_W-1:0] right_tmr;
		logic [HOLD_W-1:0] left_tmr;
		logic [HOLD_W-1:0] special_tmr;
		logic [HOLD_W-1:0] option_tmr;
		logic [BYTE_W-1:0] roll;
		logic [BYTE_W-1:0] pitch;
		logic [BYTE_W-1:0] yaw;
		logic [BYTE_W-1:0] alt;
		logic [BYTE_W-1:0] opt_num;
		logic [BYTE_W-1:0] opt_val;
	} state_t;

	typedef struct packed {
		logic              engine;
		logic              fly;
		logic [2:0]        pulses;
		logic [BYTE_W-1:0] roll;
		logic [BYTE_W-1:0] pitch;
		logic [BYTE_W-1:0] yaw;
		logic [BYTE_W-1:0] alt;
		logic [BYTE_W-1:0] opt_num;
		logic [BYTE_W-1:0] opt_val;
		logic [SEQ_W-1:0]  seq;
		logic              fault;
	} result_t;

endpackage

/* design/rc_link_frame_decoder_failsafe.sv */
// ---------------------------------------------------------------------------
// rc_link_frame_decoder_failsafe
// Receiver-side frame decoder with loss failsafe and button/option hold-off.
// ---------------------------------------------------------------------------
// One tick is taken per clock cycle, with no gaps, as long as the result side
// keeps up. Each accepted tick lands in an input register, the tick logic runs
// in the following cycle against the held link state, and the result appears
// in the output register when that register is free or drains. The link state
// loop closes through that single tick stage, so a tick always sees every
// earlier one. Thresholds and hold lengths sit in APB registers at byte
// offsets 0x00..0x10; change them only while no tick is in flight.
// ---------------------------------------------------------------------------
`include "rc_link_frame_decoder_failsafe_defines.svh"

module rc_link_frame_decoder_failsafe (
	input  logic                               clk,
	input  logic                               arst_n,
	// APB configuration
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [rclfd_pkg::ADDR_W-1:0]       paddr,
	input  logic [rclfd_pkg::DATA_W-1:0]       pwdata,
	output logic [rclfd_pkg::DATA_W-1:0]       prdata,
	output logic                               pready,
	// tick input
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic                               link_ok,
	input  logic [7:0]                         status_byte,
	input  logic signed [7:0]                  roll_in,
	input  logic signed [7:0]                  pitch_in,
	input  logic signed [7:0]                  yaw_in,
	input  logic signed [7:0]                  altitude_in,
	input  logic [7:0]                         option_number_in,
	input  logic signed [7:0]                  option_value_in,
	// result output
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic                               engine_on,
	output logic                               fly_on,
	output logic [2:0]                         button_pulses,
	output logic signed [7:0]                  roll_out,
	output logic signed [7:0]                  pitch_out,
	output logic signed [7:0]                  yaw_out,
	output logic signed [7:0]                  altitude_out,
	output logic [7:0]                         option_number_out,
	output logic signed [7:0]                  option_value_out,
	output logic [2:0]                         sequence_res,
	output logic                               link_fault
);

	rclfd_pkg::cfg_t     cfg_q;
	rclfd_pkg::state_t   state_q;
	rclfd_pkg::state_t   state_nxt;
	rclfd_pkg::item_t    item_in;
	rclfd_pkg::item_t    item_s1;
	rclfd_pkg::result_t  res_nxt;
	rclfd_pkg::result_t  res_s2;
	rclfd_pkg::reg_idx_t reg_idx;
	logic                valid_s1;
	logic                valid_s2;
	logic                adv_s1;
	logic                cfg_wr;

	// configuration registers
	assign pready  = 1'b1;
	assign reg_idx = rclfd_pkg::reg_idx_t'(paddr[4:2]);
	assign cfg_wr  = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.signal_reset <= rclfd_pkg::RST_SIGNAL_RESET;
			cfg_q.disarm       <= rclfd_pkg::RST_DISARM;
			cfg_q.fault        <= rclfd_pkg::RST_FAULT;
			cfg_q.button_hold  <= rclfd_pkg::RST_BUTTON_HOLD;
			cfg_q.option_hold  <= rclfd_pkg::RST_OPTION_HOLD;
		end else if (cfg_wr) begin
			case (reg_idx)
				rclfd_pkg::REG_SIGNAL_RESET: cfg_q.signal_reset <= pwdata[15:0];
				rclfd_pkg::REG_DISARM:       cfg_q.disarm       <= pwdata[15:0];
				rclfd_pkg::REG_FAULT:        cfg_q.fault        <= pwdata[15:0];
				rclfd_pkg::REG_BUTTON_HOLD:  cfg_q.button_hold  <= pwdata[7:0];
				rclfd_pkg::REG_OPTION_HOLD:  cfg_q.option_hold  <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	// register readback
	always_comb begin
		case (reg_idx)
			rclfd_pkg::REG_SIGNAL_RESET: prdata = {16'd0, cfg_q.signal_reset};
			rclfd_pkg::REG_DISARM:       prdata = {16'd0, cfg_q.disarm};
			rclfd_pkg::REG_FAULT:        prdata = {16'd0, cfg_q.fault};
			rclfd_pkg::REG_BUTTON_HOLD:  prdata = {24'd0, cfg_q.button_hold};
			rclfd_pkg::REG_OPTION_HOLD:  prdata = {24'd0, cfg_q.option_hold};
			default:                     prdata = '0;
		endcase
	end

	// handshake: stage 1 moves on whenever the output register is free or drains
	assign adv_s1    = valid_s1 & (~valid_s2 | out_ready);
	assign in_ready  = ~valid_s1 | adv_s1;
	assign out_valid = valid_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready)
				valid_s1 <= in_valid;
			if (adv_s1)
				valid_s2 <= 1'b1;
			else if (out_ready)
				valid_s2 <= 1'b0;
		end
	end

	// input register
	always_comb begin
		item_in.link_ok = link_ok;
		item_in.status  = status_byte;
		item_in.roll    = $unsigned(roll_in);
		item_in.pitch   = $unsigned(pitch_in);
		item_in.yaw     = $unsigned(yaw_in);
		item_in.alt     = $unsigned(altitude_in);
		item_in.opt_num = option_number_in;
		item_in.opt_val = $unsigned(option_value_in);
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready)
			item_s1 <= item_in;
	end

	// tick logic
	rclfd_tick u_tick (
		.cur  (state_q),
		.cfg  (cfg_q),
		.item (item_s1),
		.nxt  (state_nxt),
		.res  (res_nxt)
	);

	// link state, updated once per tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= '0;
		else if (adv_s1)
			state_q <= state_nxt;
	end

	// result register
	always_ff @(posedge clk) begin
		if (adv_s1)
			res_s2 <= res_nxt;
	end

	assign engine_on         = res_s2.engine;
	assign fly_on            = res_s2.fly;
	assign button_pulses     = res_s2.pulses;
	assign roll_out          = $signed(res_s2.roll);
	assign pitch_out         = $signed(res_s2.pitch);
	assign yaw_out           = $signed(res_s2.yaw);
	assign altitude_out      = $signed(res_s2.alt);
	assign option_number_out = res_s2.opt_num;
	assign option_value_out  = $signed(res_s2.opt_val);
	assign sequence_res      = res_s2.seq;
	assign link_fault        = res_s2.fault;

	// checks
	`RCLFD_ASSERT_NOW(a_fault_past_limit, adv_s1 && res_nxt.fault, state_q.loss > cfg_q.fault, "fault below limit")
	`RCLFD_ASSERT_NOW(a_fly_needs_engine, out_valid && fly_on, engine_on, "fly without engine")
	`RCLFD_ASSERT_NOW(a_ready_when_empty, !valid_s2, in_ready, "input stalled with empty output")
	`RCLFD_ASSERT_NEXT(a_loss_count, adv_s1 && !item_s1.link_ok && state_q.loss != rclfd_pkg::LOSS_MAX, state_q.loss == $past(state_q.loss) + 16'd1, "loss count step")

endmodule

/* design/rclfd_tick.sv */
// ---------------------------------------------------------------------------
// rclfd_tick
// Next-state and result logic for one control tick of the frame decoder.
// ---------------------------------------------------------------------------
module rclfd_tick (
	input  rclfd_pkg::state_t  cur,
	input  rclfd_pkg::cfg_t    cfg,
	input  rclfd_pkg::item_t   item,
	output rclfd_pkg::state_t  nxt,
	output rclfd_pkg::result_t res
);

	logic fault;

	// tick update: count, timers, loss failsafe, then frame decode
	always_comb begin
		nxt   = cur;
		fault = 1'b0;

		nxt.seq         = cur.seq + 3'd1;
		nxt.right_tmr   = (cur.right_tmr   != '0) ? cur.right_tmr   - 8'd1 : '0;
		nxt.left_tmr    = (cur.left_tmr    != '0) ? cur.left_tmr    - 8'd1 : '0;
		nxt.special_tmr = (cur.special_tmr != '0) ? cur.special_tmr - 8'd1 : '0;
		nxt.option_tmr  = (cur.option_tmr  != '0) ? cur.option_tmr  - 8'd1 : '0;

		// failsafe on long loss, judged on the count before this tick
		if (cur.loss > cfg.signal_reset) begin
			if (cur.loss > cfg.disarm) begin
				nxt.fly    = 1'b0;
				nxt.engine = 1'b0;
			end
			nxt.right_tmr   = '0;
			nxt.left_tmr    = '0;
			nxt.special_tmr = '0;
			nxt.option_tmr  = '0;
			nxt.roll        = '0;
			nxt.pitch       = '0;
			nxt.yaw         = '0;
			nxt.alt         = rclfd_pkg::ALT_LOST;
			nxt.opt_num     = '0;
			nxt.opt_val     = '0;
			fault = (cur.loss > cfg.fault) && !nxt.engine;
		end

		if (!item.link_ok) begin
			// saturating loss count
			if (cur.loss != rclfd_pkg::LOSS_MAX)
				nxt.loss = cur.loss + 16'd1;
		end else begin
			nxt.loss   = '0;
			nxt.engine = item.status[rclfd_pkg::ENGINE_BIT];
			nxt.fly    = item.status[rclfd_pkg::ENGINE_BIT] & item.status[rclfd_pkg::FLY_BIT];
			// buttons only start an idle timer
			if (item.status[rclfd_pkg::RIGHT_BIT] && nxt.right_tmr == '0)
				nxt.right_tmr = cfg.button_hold;
			if (item.status[rclfd_pkg::LEFT_BIT] && nxt.left_tmr == '0)
				nxt.left_tmr = cfg.button_hold;
			if (item.status[rclfd_pkg::SPECIAL_BIT] && nxt.special_tmr == '0)
				nxt.special_tmr = cfg.button_hold;
			nxt.seq   = item.status[rclfd_pkg::SEQ_W-1:0];
			nxt.roll  = item.roll;
			nxt.pitch = item.pitch;
			nxt.yaw   = item.yaw;
			nxt.alt   = item.alt;
			// option latch behind its own hold-off
			if (item.opt_num != '0 && nxt.option_tmr == '0) begin
				nxt.option_tmr = cfg.option_hold;
				nxt.opt_num    = item.opt_num;
				nxt.opt_val    = item.opt_val;
			end else begin
				nxt.opt_num = '0;
				nxt.opt_val = '0;
			end
		end
	end

	// result fields from the updated state, plus the fault flag
	always_comb begin
		res.engine    = nxt.engine;
		res.fly       = nxt.fly;
		res.pulses[0] = (nxt.right_tmr   == cfg.button_hold);
		res.pulses[1] = (nxt.left_tmr    == cfg.button_hold);
		res.pulses[2] = (nxt.special_tmr == cfg.button_hold);
		res.roll      = nxt.roll;
		res.pitch     = nxt.pitch;
		res.yaw       = nxt.yaw;
		res.alt       = nxt.alt;
		res.opt_num   = nxt.opt_num;
		res.opt_val   = nxt.opt_val;
		res.seq       = nxt.seq;
		res.fault     = fault;
	end

endmodule
